// ===== rtl/stable_priority_queue_top_defines.svh =====
// Assertion macros used by the checker file.
`ifndef STABLE_PRIORITY_QUEUE_TOP_DEFINES_SVH
`define STABLE_PRIORITY_QUEUE_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define SPQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define SPQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/spq_pkg.sv =====
package spq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_REMOVE = 1'b1;

  localparam logic [1:0] STATUS_DONE  = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  typedef struct packed {
    logic               req_type;
    logic signed [31:0] data_value;
    logic signed [15:0] priority_req;
  } in_req_t;

  typedef struct packed {
    logic signed [31:0] data_out;
    logic        [1:0]  status;
    logic        [4:0]  entry_count;
  } out_res_t;

  // controller -> datapath
  typedef struct packed {
    logic load_req;
    logic exec;
  } spq_cmd_t;

endpackage

// ===== rtl/spq_ctrl.sv =====
module spq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output spq_pkg::spq_cmd_t cmd
);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;
  logic   exec;

  assign in_stall = (state_r != S_IDLE);
  // run once the output register is free or being drained this cycle
  assign exec     = (state_r == S_EXEC) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (exec) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign cmd.load_req = in_valid && !in_stall;
  assign cmd.exec     = exec;

endmodule

// ===== rtl/spq_datapath.sv =====
module spq_datapath (
  input  logic              clk,
  input  logic              rst_n,
  input  spq_pkg::spq_cmd_t cmd,
  input  spq_pkg::in_req_t  in_req,
  output spq_pkg::out_res_t out_res
);

  localparam int D = spq_pkg::QUEUE_DEPTH;
  localparam int W = spq_pkg::CNT_W;

  spq_pkg::in_req_t   req_r;
  spq_pkg::out_res_t  out_res_r;
  spq_pkg::out_res_t  out_res_nxt;
  logic [W-1:0]       count_r;
  logic [W-1:0]       count_nxt;
  logic signed [31:0] cell_data_r   [D];
  logic signed [15:0] cell_pri_r    [D];
  logic signed [31:0] cell_data_nxt [D];
  logic signed [15:0] cell_pri_nxt  [D];
  logic [D-1:0]       le;
  logic               full;
  logic               empty;
  logic               do_ins;
  logic               do_rem;
  logic [W+4:0]       cnt_ext;

  assign full   = (count_r == W'(D));
  assign empty  = (count_r == '0);
  assign do_ins = (req_r.req_type == spq_pkg::REQ_INSERT) && !full;
  assign do_rem = (req_r.req_type == spq_pkg::REQ_REMOVE) && !empty;

  // Each cell: occupied and not above the new priority. Sorted, so le is a prefix.
  for (genvar g = 0; g < D; g++) begin : g_cell
    logic prev_le;
    if (g == 0) begin : g_head
      assign prev_le = 1'b1;
    end else begin : g_body
      assign prev_le = le[g-1];
    end

    assign le[g] = (W'(g) < count_r) && (cell_pri_r[g] <= req_r.priority_req);

    always_comb begin
      cell_data_nxt[g] = cell_data_r[g];
      cell_pri_nxt[g]  = cell_pri_r[g];
      if (do_ins && !le[g]) begin
        if (prev_le) begin
          cell_data_nxt[g] = req_r.data_value;
          cell_pri_nxt[g]  = req_r.priority_req;
        end else begin
          cell_data_nxt[g] = cell_data_r[g-((g > 0) ? 1 : 0)];
          cell_pri_nxt[g]  = cell_pri_r[g-((g > 0) ? 1 : 0)];
        end
      end else if (do_rem) begin
        cell_data_nxt[g] = cell_data_r[g+((g < D-1) ? 1 : 0)];
        cell_pri_nxt[g]  = cell_pri_r[g+((g < D-1) ? 1 : 0)];
      end
    end

    always_ff @(posedge clk) begin
      if (cmd.exec) begin
        cell_data_r[g] <= cell_data_nxt[g];
        cell_pri_r[g]  <= cell_pri_nxt[g];
      end
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (do_ins) begin
      count_nxt = count_r + W'(1);
    end else if (do_rem) begin
      count_nxt = count_r - W'(1);
    end
  end

  // entry_count is the low five bits of the count
  assign cnt_ext = {5'b0, count_nxt};

  always_comb begin
    out_res_nxt.data_out    = '0;
    out_res_nxt.status      = spq_pkg::STATUS_DONE;
    out_res_nxt.entry_count = cnt_ext[4:0];
    if (req_r.req_type == spq_pkg::REQ_INSERT) begin
      if (full) begin
        out_res_nxt.status = spq_pkg::STATUS_FULL;
      end
    end else begin
      if (empty) begin
        out_res_nxt.status = spq_pkg::STATUS_EMPTY;
      end else begin
        out_res_nxt.data_out = cell_data_r[0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.exec) begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_r <= in_req;
    end
    if (cmd.exec) begin
      out_res_r <= out_res_nxt;
    end
  end

  assign out_res = out_res_r;

endmodule

// ===== rtl/stable_priority_queue_top.sv =====
// Stable priority queue of spq_pkg::QUEUE_DEPTH entries (16), smallest priority
// first, kept sorted in a row of shifting cells. An insert request places its
// data behind every stored entry of lower or equal priority, so equal
// priorities leave in arrival order; a remove request returns the head data.
// Every request gives exactly one result with status done, empty (remove on an
// empty queue, data_out zero) or full (insert on a full queue, nothing stored),
// plus the entry count after the request. A request is first captured in a
// register, then executed, all cells comparing in parallel and shifting together;
// the next request is taken while the previous result still waits on out_stall,
// and execution waits only until the output register is free.
module stable_priority_queue_top (
  input  logic              clk,
  input  logic              rst_n,
  // request channel
  input  logic              in_valid,
  output logic              in_stall,
  input  spq_pkg::in_req_t  in_req,
  // result channel
  output logic              out_valid,
  input  logic              out_stall,
  output spq_pkg::out_res_t out_res
);

  // load_req captures a request, exec applies it to the cells
  spq_pkg::spq_cmd_t cmd;

  spq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // cells, count, request and result registers
  spq_datapath u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .in_req  (in_req),
    .out_res (out_res)
  );

endmodule

// ===== rtl/spq_checker.sv =====
`include "stable_priority_queue_top_defines.svh"

module spq_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input spq_pkg::in_req_t  in_req,
  input logic              out_valid,
  input logic              out_stall,
  input spq_pkg::out_res_t out_res
);

  localparam logic [4:0] FULL_CNT = 5'(spq_pkg::QUEUE_DEPTH);

  `SPQ_ASSERT_NEXT(a_in_hold, in_valid && in_stall,
                   in_valid && $stable(in_req), "stalled request changed")
  `SPQ_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
                   out_valid && $stable(out_res), "stalled result changed")
  `SPQ_ASSERT_NOW(a_status_code, out_valid,
                  out_res.status == spq_pkg::STATUS_DONE ||
                  out_res.status == spq_pkg::STATUS_EMPTY ||
                  out_res.status == spq_pkg::STATUS_FULL, "bad status code")
  `SPQ_ASSERT_NOW(a_empty_res, out_valid && out_res.status == spq_pkg::STATUS_EMPTY,
                  out_res.entry_count == 5'd0 && out_res.data_out == 32'sd0,
                  "empty result inconsistent")
  `SPQ_ASSERT_NOW(a_full_res, out_valid && out_res.status == spq_pkg::STATUS_FULL,
                  out_res.entry_count == FULL_CNT && out_res.data_out == 32'sd0,
                  "full result inconsistent")

endmodule

bind stable_priority_queue_top spq_checker u_spq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_req    (in_req),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_res   (out_res)
);
